// File: design/utf8e_pkg.sv
// utf8e_pkg: shared constants, request types and encoding helpers for the
// utf16 to utf8 encoder; depends on nothing
package utf8e_pkg;

  localparam int UNIT_W      = 16;
  localparam int BYTE_W      = 8;
  localparam int MAX_BYTES   = 6;
  localparam int CNT_W       = 3;
  localparam int QUEUE_DEPTH = 2;

  // utf-8 range limits and marker bits
  localparam logic [UNIT_W-1:0] LIMIT_ONE = 16'h0080;
  localparam logic [UNIT_W-1:0] LIMIT_TWO = 16'h0800;
  localparam logic [BYTE_W-1:0] CONT_MARK = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD_TWO  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD_THR  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_FOUR = 8'hF0;
  localparam logic [5:0]        HIGH_TAG  = 6'b110110;
  localparam logic [5:0]        LOW_TAG   = 6'b110111;
  localparam logic [20:0]       SUPP_BASE = 21'h10000;

  typedef logic [BYTE_W-1:0] byte_t;

  // one request: the bytes one input item causes, lowest index goes first
  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]                 cnt;
  } job_t;

  // byte count of a lone unit
  function automatic logic [1:0] unit_len(input logic [UNIT_W-1:0] u);
    logic [1:0] n;
    if (u < LIMIT_ONE) begin
      n = 2'd1;
    end else if (u < LIMIT_TWO) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  // bytes of a lone unit, element 0 first
  function automatic logic [2:0][BYTE_W-1:0] unit_bytes(input logic [UNIT_W-1:0] u);
    logic [2:0][BYTE_W-1:0] b;
    b = '0;
    if (u < LIMIT_ONE) begin
      b[0] = u[7:0];
    end else if (u < LIMIT_TWO) begin
      b[0] = LEAD_TWO | {3'b000, u[10:6]};
      b[1] = CONT_MARK | {2'b00, u[5:0]};
    end else begin
      b[0] = LEAD_THR | {4'b0000, u[15:12]};
      b[1] = CONT_MARK | {2'b00, u[11:6]};
      b[2] = CONT_MARK | {2'b00, u[5:0]};
    end
    return b;
  endfunction

  // four bytes of a supplementary code point
  function automatic logic [3:0][BYTE_W-1:0] pair_bytes(input logic [20:0] cp);
    logic [3:0][BYTE_W-1:0] b;
    b[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
    b[1] = CONT_MARK | {2'b00, cp[17:12]};
    b[2] = CONT_MARK | {2'b00, cp[11:6]};
    b[3] = CONT_MARK | {2'b00, cp[5:0]};
    return b;
  endfunction

endpackage

// File: design/utf8e_front.sv
// utf8e_front: accepts code units, tracks the held high surrogate and builds
// one byte request per item; depends on utf8e_pkg
module utf8e_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [utf8e_pkg::UNIT_W-1:0]     in_code_unit,
  input  logic                             in_end_of_string,
  input  logic                             q_full,
  output logic                             q_push,
  output utf8e_pkg::job_t                  q_job
);

  logic       held_valid_r, held_valid_nxt;
  logic [9:0] held_unit_r, held_unit_nxt;
  logic       accept, is_high, is_low, flush, emit_new;
  logic [20:0] cp;
  logic [3:0][utf8e_pkg::BYTE_W-1:0] pb;
  logic [2:0][utf8e_pkg::BYTE_W-1:0] hb, nb;
  logic [1:0] new_len;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // classify the unit
  assign is_high  = (in_code_unit[15:10] == utf8e_pkg::HIGH_TAG);
  assign is_low   = (in_code_unit[15:10] == utf8e_pkg::LOW_TAG);
  assign cp       = utf8e_pkg::SUPP_BASE + {1'b0, held_unit_r, in_code_unit[9:0]};
  assign pb       = utf8e_pkg::pair_bytes(cp);
  assign hb       = utf8e_pkg::unit_bytes({utf8e_pkg::HIGH_TAG, held_unit_r});
  assign nb       = utf8e_pkg::unit_bytes(in_code_unit);
  assign new_len  = utf8e_pkg::unit_len(in_code_unit);
  assign flush    = held_valid_r && !is_low;
  assign emit_new = !(is_high && !in_end_of_string);

  // build the request and next surrogate state
  always_comb begin
    q_job          = '0;
    held_valid_nxt = held_valid_r;
    held_unit_nxt  = held_unit_r;
    if (held_valid_r && is_low) begin
      q_job.bytes[3:0] = pb;
      q_job.cnt        = 3'd4;
      held_valid_nxt   = 1'b0;
      held_unit_nxt    = '0;
    end else begin
      if (flush) begin
        q_job.bytes[2:0] = hb;
        q_job.cnt        = 3'd3;
        held_valid_nxt   = 1'b0;
        held_unit_nxt    = '0;
      end
      if (emit_new) begin
        if (flush) begin
          q_job.bytes[5:3] = nb;
          q_job.cnt        = 3'd3 + {1'b0, new_len};
        end else begin
          q_job.bytes[2:0] = nb;
          q_job.cnt        = {1'b0, new_len};
        end
      end else begin
        held_valid_nxt = 1'b1;
        held_unit_nxt  = in_code_unit[9:0];
      end
    end
  end

  // a held high surrogate alone causes no bytes
  assign q_push = accept && (q_job.cnt != '0);

  // surrogate state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_unit_r  <= '0;
    end else if (accept) begin
      held_valid_r <= held_valid_nxt;
      held_unit_r  <= held_unit_nxt;
    end
  end

endmodule

// File: design/utf8e_queue.sv
// utf8e_queue: short request queue between front and back
// depends on utf8e_pkg
module utf8e_queue #(
  parameter int DEPTH = utf8e_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  utf8e_pkg::job_t push_job,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output utf8e_pkg::job_t head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  utf8e_pkg::job_t  store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = store_r[rd_ptr_r];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: design/utf8e_back.sv
// utf8e_back: walks the head request into the output register one byte a cycle
// while out_ready allows it; depends on utf8e_pkg
module utf8e_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           head_valid,
  input  utf8e_pkg::job_t                head_job,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [utf8e_pkg::BYTE_W-1:0]   out_byte,
  output logic                           out_last_of_run
);

  logic [utf8e_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [utf8e_pkg::BYTE_W-1:0] out_byte_r;
  logic                         out_last_r;
  logic                         load, last;

  assign load = head_valid && (!out_valid_r || out_ready);
  assign last = (idx_r == head_job.cnt - 1'b1);
  assign pop  = load && last;

  // byte index and output occupancy
  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = last ? '0 : idx_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= head_job.bytes[idx_r];
      out_last_r <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

endmodule

// File: design/utf16_to_utf8_encoder.sv
// utf16_to_utf8_encoder: top level, front classifier, request queue and byte
// serializer; depends on utf8e_pkg, utf8e_front, utf8e_queue, utf8e_back
//
//   channel | direction | ports
//   --------+-----------+-----------------------------------------------
//   input   | in        | in_valid/in_ready, in_code_unit, in_end_of_string
//   result  | out       | out_valid/out_ready, out_byte, out_last_of_run
//
// one byte leaves per cycle while out is not stalled; an item gives 1 to 3 bytes
// for a lone unit, 4 for a pair, up to 6 when a held surrogate flushes and 0
// for a held high surrogate. from accept to first byte with an empty queue, a
// request passes the queue entry and then the output register.
// reset clears the held surrogate, the queue and the output valid bit.
// the front keeps accepting while the queue has room, even when out is stalled.
module utf16_to_utf8_encoder #(
  parameter int QUEUE_DEPTH = utf8e_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [utf8e_pkg::UNIT_W-1:0]   in_code_unit,
  input  logic                           in_end_of_string,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [utf8e_pkg::BYTE_W-1:0]   out_byte,
  output logic                           out_last_of_run
);

  logic            q_full, q_push, q_pop, q_head_valid;
  utf8e_pkg::job_t q_job, q_head;

  utf8e_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_code_unit     (in_code_unit),
    .in_end_of_string (in_end_of_string),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_job            (q_job)
  );

  utf8e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_job   (q_head)
  );

  utf8e_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_head_valid),
    .head_job        (q_head),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// File: design/utf8e_checker.sv
// utf8e_checker: port-level checks on the encoder's byte stream, with bind
// depends on utf16_to_utf8_encoder ports only
module utf8e_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last_of_run
);

  // a stalled byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last_of_run))
    else $error("result byte changed while stalled");

  // nothing shows right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a single-byte form always ends its run
  a_ascii_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte[7] |-> out_last_of_run)
    else $error("ascii byte not marked last");

  // a multi-byte lead never ends a run
  a_lead_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte[7:6] == 2'b11 |-> !out_last_of_run)
    else $error("lead byte marked last");

  // no lead byte beyond the four-byte form
  a_lead_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte[7:3] != 5'b11111)
    else $error("illegal utf-8 lead byte");

endmodule

bind utf16_to_utf8_encoder utf8e_checker u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte        (out_byte),
  .out_last_of_run (out_last_of_run)
);

// File: tb/sv/testbench.sv
// testbench: utf-16 to utf-8 encoder, a directed table then random well-formed and broken
// unit streams, every byte checked against the typed table rows or a predictor; depends on utf8e_pkg and the encoder
module testbench;

  localparam int N_DIRECT    = 25;
  localparam int N_RANDOM    = 185;
  localparam int HOLD_LEN    = 160;
  localparam int TAIL_CYCLES = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_SHOWN   = 10;

  // one row of stimulus; typed rows carry their bytes, first byte in the top lane
  typedef struct packed {
    logic [utf8e_pkg::UNIT_W-1:0]                     unit;
    logic                                             eos;
    logic                                             typed;
    logic [utf8e_pkg::CNT_W-1:0]                      cnt;
    logic [utf8e_pkg::MAX_BYTES*utf8e_pkg::BYTE_W-1:0] bytes;
  } unit_row_t;

  typedef struct packed {
    utf8e_pkg::byte_t data;
    logic             last;
  } utf8_byte_t;

  localparam unit_row_t DIR_TAB [N_DIRECT] = '{
    // plain units at the range edges
    '{16'h0000, 1'b0, 1'b1, 3'd1, 48'h00_00_00_00_00_00},
    '{16'h007F, 1'b0, 1'b1, 3'd1, 48'h7F_00_00_00_00_00},
    '{16'h0080, 1'b1, 1'b1, 3'd2, 48'hC2_80_00_00_00_00},
    '{16'h07FF, 1'b0, 1'b1, 3'd2, 48'hDF_BF_00_00_00_00},
    '{16'h0800, 1'b0, 1'b1, 3'd3, 48'hE0_A0_80_00_00_00},
    '{16'hFFFF, 1'b1, 1'b1, 3'd3, 48'hEF_BF_BF_00_00_00},
    // lowest and highest surrogate pairs, the second ending the string
    '{16'hD800, 1'b0, 1'b1, 3'd0, 48'h00_00_00_00_00_00},
    '{16'hDC00, 1'b0, 1'b1, 3'd4, 48'hF0_90_80_80_00_00},
    '{16'hDBFF, 1'b0, 1'b1, 3'd0, 48'h00_00_00_00_00_00},
    '{16'hDFFF, 1'b1, 1'b1, 3'd4, 48'hF4_8F_BF_BF_00_00},
    // unpaired low, and a high surrogate that ends the string
    '{16'hDC00, 1'b0, 1'b1, 3'd3, 48'hED_B0_80_00_00_00},
    '{16'hD800, 1'b1, 1'b1, 3'd3, 48'hED_A0_80_00_00_00},
    // held high flushed by a plain unit
    '{16'hDABC, 1'b0, 1'b1, 3'd0, 48'h00_00_00_00_00_00},
    '{16'h0041, 1'b0, 1'b1, 3'd4, 48'hED_AA_BC_41_00_00},
    // held high flushed by another high, which is held in turn
    '{16'hD801, 1'b0, 1'b0, 3'd0, 48'h0},
    '{16'hD802, 1'b0, 1'b0, 3'd0, 48'h0},
    '{16'h0800, 1'b1, 1'b0, 3'd0, 48'h0},
    // held high flushed by a high with end of string
    '{16'hDBFF, 1'b0, 1'b0, 3'd0, 48'h0},
    '{16'hD800, 1'b1, 1'b0, 3'd0, 48'h0},
    // alternating bit patterns
    '{16'h5555, 1'b1, 1'b0, 3'd0, 48'h0},
    '{16'hAAAA, 1'b0, 1'b0, 3'd0, 48'h0},
    // ordinary pair
    '{16'hD83D, 1'b0, 1'b0, 3'd0, 48'h0},
    '{16'hDE00, 1'b0, 1'b0, 3'd0, 48'h0},
    // held high flushed by the largest unit with end of string
    '{16'hDBFF, 1'b0, 1'b0, 3'd0, 48'h0},
    '{16'hFFFF, 1'b1, 1'b0, 3'd0, 48'h0}
  };

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [utf8e_pkg::UNIT_W-1:0] in_code_unit = '0;
  logic                         in_end_of_string = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  utf8e_pkg::byte_t             out_byte;
  logic                         out_last_of_run;

  // predictor state: held high surrogate
  logic [9:0] held_bits = '0;
  logic       held_on = 1'b0;

  utf8e_pkg::byte_t run_bytes [$];
  utf8_byte_t       due_bytes [$];
  int               mismatch_cnt = 0;
  int               reqs_sent = 0;
  int               burst_left = 0;
  bit               hold_req = 1'b0;
  bit               rx_holding = 1'b0;

  utf16_to_utf8_encoder uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_code_unit     (in_code_unit),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // bytes of a unit encoded on its own
  function automatic void add_lone_unit(input logic [utf8e_pkg::UNIT_W-1:0] u);
    if (u < 16'h0080) begin
      run_bytes.push_back(u[7:0]);
    end else if (u < 16'h0800) begin
      run_bytes.push_back(8'hC0 | {3'b000, u[10:6]});
      run_bytes.push_back(8'h80 | {2'b00, u[5:0]});
    end else begin
      run_bytes.push_back(8'hE0 | {4'b0000, u[15:12]});
      run_bytes.push_back(8'h80 | {2'b00, u[11:6]});
      run_bytes.push_back(8'h80 | {2'b00, u[5:0]});
    end
  endfunction

  // four bytes of a supplementary code point
  function automatic void add_code_point(input logic [20:0] cp);
    run_bytes.push_back(8'hF0 | {5'b00000, cp[20:18]});
    run_bytes.push_back(8'h80 | {2'b00, cp[17:12]});
    run_bytes.push_back(8'h80 | {2'b00, cp[11:6]});
    run_bytes.push_back(8'h80 | {2'b00, cp[5:0]});
  endfunction

  // bytes one request causes, updating the held surrogate
  function automatic void encode_unit(input logic [utf8e_pkg::UNIT_W-1:0] u, input logic eos);
    logic       is_high;
    logic       is_low;
    logic [20:0] cp;
    is_high = (u[15:10] == utf8e_pkg::HIGH_TAG);
    is_low  = (u[15:10] == utf8e_pkg::LOW_TAG);
    run_bytes.delete();
    if (held_on && is_low) begin
      cp = utf8e_pkg::SUPP_BASE + {1'b0, held_bits, u[9:0]};
      add_code_point(cp);
      held_on = 1'b0;
      held_bits = '0;
    end else begin
      if (held_on) begin
        add_lone_unit({utf8e_pkg::HIGH_TAG, held_bits});
        held_on = 1'b0;
        held_bits = '0;
      end
      if (is_high && !eos) begin
        held_bits = u[9:0];
        held_on = 1'b1;
      end else begin
        add_lone_unit(u);
      end
    end
  endfunction

  // offer one request, record its bytes on accept, then pace the next one
  task automatic offer_unit(input unit_row_t r);
    int k;
    int gap;
    in_valid <= 1'b1;
    in_code_unit <= r.unit;
    in_end_of_string <= r.eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    encode_unit(r.unit, r.eos);
    if (r.typed) begin
      run_bytes.delete();
      for (k = 0; k < r.cnt; k++) begin
        run_bytes.push_back(
          r.bytes[(utf8e_pkg::MAX_BYTES-1-k)*utf8e_pkg::BYTE_W +: utf8e_pkg::BYTE_W]);
      end
    end
    for (k = 0; k < run_bytes.size(); k++) begin
      due_bytes.push_back('{run_bytes[k], k == run_bytes.size() - 1});
    end
    reqs_sent++;
    @(negedge clk);
    // bursts of random length, random gaps between them
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 11);
      gap = rx_holding ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic send_unit(input logic [utf8e_pkg::UNIT_W-1:0] u, input logic eos);
    unit_row_t r;
    r = '{u, eos, 1'b0, '0, '0};
    offer_unit(r);
  endtask

  task automatic note_mismatch(input string what, input utf8_byte_t want);
    if (mismatch_cnt < MAX_SHOWN) begin
      $display("mismatch (%s): expected byte %h last %b, got byte %h last %b",
               what, want.data, want.last, out_byte, out_last_of_run);
    end
    mismatch_cnt++;
  endtask

  // result checker
  always @(posedge clk) begin : check_out
    utf8_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_bytes.size() == 0) begin
        want = '0;
        note_mismatch("no byte expected", want);
      end else begin
        want = due_bytes.pop_front();
        if (want.data !== out_byte || want.last !== out_last_of_run) begin
          note_mismatch("wrong byte", want);
        end
      end
    end
  end

  // receiver: windows of always ready, random and mostly stalled, plus one long hold-off
  initial begin
    int win_left;
    int mode;
    int k;
    win_left = 0;
    mode = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rx_holding = 1'b1;
        out_ready <= 1'b0;
        for (k = 0; k < HOLD_LEN; k++) @(negedge clk);
        rx_holding = 1'b0;
      end
      if (win_left == 0) begin
        mode = $urandom_range(0, 2);
        win_left = $urandom_range(8, 40);
      end
      win_left--;
      case (mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= ($urandom_range(0, 1) == 1);
        end
        default: begin
          out_ready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // run limit
  initial begin
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // stimulus
  initial begin
    int   i;
    int   pick;
    bit   hold_done;
    bit   drain_done;
    logic [utf8e_pkg::UNIT_W-1:0] u;
    logic eos;
    hold_done = 1'b0;
    drain_done = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < N_DIRECT; i++) offer_unit(DIR_TAB[i]);

    while (reqs_sent < N_DIRECT + N_RANDOM) begin
      // long receiver hold-off while requests keep coming
      if (!hold_done && reqs_sent >= N_DIRECT + 60) begin
        hold_done = 1'b1;
        hold_req = 1'b1;
      end
      // pause until every expected byte is out
      if (!drain_done && reqs_sent >= N_DIRECT + 140) begin
        drain_done = 1'b1;
        in_valid <= 1'b0;
        while (due_bytes.size() != 0) @(negedge clk);
        @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      eos = ($urandom_range(0, 5) == 0);
      u = 16'($urandom);
      if (pick < 16) begin
        send_unit({9'd0, u[6:0]}, eos);
      end else if (pick < 30) begin
        send_unit(16'($urandom_range(16'h0080, 16'h07FF)), eos);
      end else if (pick < 44) begin
        // three-byte unit outside the surrogate range
        u = 16'($urandom_range(16'h0800, 16'hFFFF));
        if (u[15:11] == 5'b11011) u[13] = ~u[13];
        send_unit(u, eos);
      end else if (pick < 76) begin
        // well-formed pair
        send_unit({utf8e_pkg::HIGH_TAG, u[9:0]}, 1'b0);
        u = 16'($urandom);
        send_unit({utf8e_pkg::LOW_TAG, u[9:0]}, eos);
      end else if (pick < 84) begin
        // high surrogate followed by anything but a low one
        send_unit({utf8e_pkg::HIGH_TAG, u[9:0]}, ($urandom_range(0, 3) == 0));
        u = 16'($urandom);
        if (u[15:10] == utf8e_pkg::LOW_TAG) u[10] = 1'b0;
        send_unit(u, eos);
      end else if (pick < 90) begin
        send_unit({utf8e_pkg::LOW_TAG, u[9:0]}, eos);
      end else begin
        send_unit(u, ($urandom_range(0, 1) == 1));
      end
    end
    in_valid <= 1'b0;

    while (due_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && due_bytes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
design/utf8e_pkg.sv
design/utf8e_front.sv
design/utf8e_queue.sv
design/utf8e_back.sv
design/utf16_to_utf8_encoder.sv
design/utf8e_checker.sv
tb/sv/testbench.sv
